[rtl/core/asm_line_tokenizer_macros.svh]
// ----------------------------------------------------------------------------
// asm line tokenizer assertion macros
// shared concurrent assertion forms, reset-qualified
// ----------------------------------------------------------------------------
`ifndef ASM_LINE_TOKENIZER_MACROS_SVH
`define ASM_LINE_TOKENIZER_MACROS_SVH

// same-cycle implication
`define ALT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ALT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/alt_pkg.sv]
// ----------------------------------------------------------------------------
// alt_pkg
// types, constants and character codes of the assembler line tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package alt_pkg;

  localparam int MAX_TOKEN_LEN = 32;
  localparam int COLUMN_BITS   = 16;
  localparam int START_W       = 16;
  localparam int LEN_W         = 6;
  localparam int KIND_W        = 2;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LONG  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd2;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_DQUOTE = 2'd1,
    MODE_APOS   = 2'd2,
    MODE_ANGLE  = 2'd3
  } span_mode_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [START_W-1:0] start_column;
    logic [LEN_W-1:0]   token_length;
    logic [KIND_W-1:0]  token_kind;
    logic               last;
  } out_t;

  typedef struct packed {
    logic two;
    out_t d0;
    out_t d1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic hold_valid;
    logic hold_last;
  } back_stat_t;

endpackage

`default_nettype wire

[rtl/core/alt_front.sv]
// ----------------------------------------------------------------------------
// alt_front
// per-character tokenizer state; builds up to two descriptors per item
// ----------------------------------------------------------------------------
`default_nettype none

module alt_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire alt_pkg::in_t  in_data,
  input  wire alt_pkg::q_stat_t q_stat,
  output logic               in_ready,
  output logic               push,
  output alt_pkg::entry_t    push_data
);

  typedef struct packed {
    logic [1:0]  cnt;
    alt_pkg::out_t d0;
    alt_pkg::out_t d1;
  } acc_t;

  logic [alt_pkg::COLUMN_BITS-1:0] col_r, col_nxt;
  logic                            open_r, open_nxt;
  alt_pkg::span_mode_t             mode_r, mode_nxt;
  logic [alt_pkg::COLUMN_BITS-1:0] ostart_r, ostart_nxt;
  logic [alt_pkg::LEN_W-1:0]       olen_r, olen_nxt;
  logic [alt_pkg::KIND_W-1:0]      okind_r, okind_nxt;
  logic                            pbs_r, pbs_nxt;
  logic                            cmt_r, cmt_nxt;
  acc_t                            acc;

  function automatic logic is_punct(input logic [7:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      alt_pkg::CH_COLON, alt_pkg::CH_LPAREN, alt_pkg::CH_RPAREN, alt_pkg::CH_PLUS,
      alt_pkg::CH_MINUS, alt_pkg::CH_STAR, alt_pkg::CH_SLASH, alt_pkg::CH_COMMA: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic acc_t add(input acc_t a, input logic [alt_pkg::COLUMN_BITS-1:0] s,
                               input logic [alt_pkg::LEN_W-1:0] l,
                               input logic [alt_pkg::KIND_W-1:0] k);
    acc_t          r;
    alt_pkg::out_t d;
    r = a;
    d.start_column = alt_pkg::START_W'(s);
    d.token_length = l;
    d.token_kind   = k;
    d.last         = 1'b0;
    if (a.cnt == 2'd0) begin
      r.d0  = d;
      r.cnt = 2'd1;
    end else if (a.cnt == 2'd1) begin
      r.d1  = d;
      r.cnt = 2'd2;
    end
    return r;
  endfunction

  logic [7:0] c;
  logic       sep;
  logic [7:0] closer;

  assign c   = in_data.char_in;
  assign sep = (c == alt_pkg::CH_SPACE) || (c == alt_pkg::CH_TAB);

  always_comb begin
    col_nxt    = col_r;
    open_nxt   = open_r;
    mode_nxt   = mode_r;
    ostart_nxt = ostart_r;
    olen_nxt   = olen_r;
    okind_nxt  = okind_r;
    pbs_nxt    = pbs_r;
    cmt_nxt    = cmt_r;
    acc        = '0;
    closer     = alt_pkg::CH_GT;

    if (!cmt_r) begin
      // full token is cut before this character
      if (open_nxt && olen_nxt >= alt_pkg::LEN_W'(alt_pkg::MAX_TOKEN_LEN)) begin
        acc        = add(acc, ostart_nxt, olen_nxt, alt_pkg::KIND_LONG);
        open_nxt   = 1'b0;
        mode_nxt   = alt_pkg::MODE_PLAIN;
        ostart_nxt = '0;
        olen_nxt   = '0;
        okind_nxt  = alt_pkg::KIND_PLAIN;
        pbs_nxt    = 1'b0;
      end
      if (open_nxt && mode_nxt == alt_pkg::MODE_PLAIN &&
          (sep || c == alt_pkg::CH_SEMI || is_punct(c))) begin
        acc        = add(acc, ostart_nxt, olen_nxt, okind_nxt);
        open_nxt   = 1'b0;
        mode_nxt   = alt_pkg::MODE_PLAIN;
        ostart_nxt = '0;
        olen_nxt   = '0;
        okind_nxt  = alt_pkg::KIND_PLAIN;
        pbs_nxt    = 1'b0;
      end
      if (!open_nxt) begin
        if (sep) begin
          cmt_nxt = 1'b0;
        end else if (c == alt_pkg::CH_SEMI) begin
          cmt_nxt = 1'b1;
        end else if (is_punct(c)) begin
          acc = add(acc, col_r, alt_pkg::LEN_W'(1), alt_pkg::KIND_PLAIN);
        end else begin
          open_nxt   = 1'b1;
          ostart_nxt = col_r;
          olen_nxt   = '0;
          okind_nxt  = alt_pkg::KIND_PLAIN;
          mode_nxt   = alt_pkg::MODE_PLAIN;
          pbs_nxt    = 1'b0;
        end
      end
      if (open_nxt) begin
        unique case (mode_nxt)
          alt_pkg::MODE_DQUOTE: closer = alt_pkg::CH_DQUOTE;
          alt_pkg::MODE_APOS:   closer = alt_pkg::CH_APOS;
          default:              closer = alt_pkg::CH_GT;
        endcase
        if (mode_nxt == alt_pkg::MODE_PLAIN) begin
          if (c == alt_pkg::CH_DQUOTE) begin
            mode_nxt  = alt_pkg::MODE_DQUOTE;
            okind_nxt = alt_pkg::KIND_OPEN;
          end else if (c == alt_pkg::CH_APOS) begin
            mode_nxt  = alt_pkg::MODE_APOS;
            okind_nxt = alt_pkg::KIND_OPEN;
          end else if (c == alt_pkg::CH_LT) begin
            mode_nxt  = alt_pkg::MODE_ANGLE;
            okind_nxt = alt_pkg::KIND_OPEN;
          end
          if (olen_nxt != '1) olen_nxt = olen_nxt + alt_pkg::LEN_W'(1);
          pbs_nxt = (c == alt_pkg::CH_BSLASH);
        end else if (c == closer && !pbs_nxt) begin
          if (olen_nxt != '1) olen_nxt = olen_nxt + alt_pkg::LEN_W'(1);
          acc        = add(acc, ostart_nxt, olen_nxt, alt_pkg::KIND_PLAIN);
          open_nxt   = 1'b0;
          mode_nxt   = alt_pkg::MODE_PLAIN;
          ostart_nxt = '0;
          olen_nxt   = '0;
          okind_nxt  = alt_pkg::KIND_PLAIN;
          pbs_nxt    = 1'b0;
        end else begin
          if (olen_nxt != '1) olen_nxt = olen_nxt + alt_pkg::LEN_W'(1);
          pbs_nxt = (c == alt_pkg::CH_BSLASH);
        end
      end
    end

    if (in_data.line_end) begin
      if (open_nxt) acc = add(acc, ostart_nxt, olen_nxt, okind_nxt);
      open_nxt   = 1'b0;
      mode_nxt   = alt_pkg::MODE_PLAIN;
      ostart_nxt = '0;
      olen_nxt   = '0;
      okind_nxt  = alt_pkg::KIND_PLAIN;
      pbs_nxt    = 1'b0;
      cmt_nxt    = 1'b0;
      col_nxt    = '0;
    end else if (col_r != '1) begin
      col_nxt = col_r + alt_pkg::COLUMN_BITS'(1);
    end

    if (acc.cnt == 2'd1) acc.d0.last = 1'b1;
    if (acc.cnt == 2'd2) acc.d1.last = 1'b1;
  end

  assign in_ready      = !q_stat.full;
  assign push          = in_valid && in_ready && (acc.cnt != 2'd0);
  assign push_data.two = acc.cnt[1];
  assign push_data.d0  = acc.d0;
  assign push_data.d1  = acc.d1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      open_r   <= 1'b0;
      mode_r   <= alt_pkg::MODE_PLAIN;
      ostart_r <= '0;
      olen_r   <= '0;
      okind_r  <= alt_pkg::KIND_PLAIN;
      pbs_r    <= 1'b0;
      cmt_r    <= 1'b0;
    end else if (in_valid && in_ready) begin
      col_r    <= col_nxt;
      open_r   <= open_nxt;
      mode_r   <= mode_nxt;
      ostart_r <= ostart_nxt;
      olen_r   <= olen_nxt;
      okind_r  <= okind_nxt;
      pbs_r    <= pbs_nxt;
      cmt_r    <= cmt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/alt_queue.sv]
// ----------------------------------------------------------------------------
// alt_queue
// short queue of descriptor pairs between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module alt_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire alt_pkg::entry_t push_data,
  input  wire logic            pop,
  output alt_pkg::entry_t      head,
  output alt_pkg::q_stat_t     q_stat
);

  alt_pkg::entry_t                 mem_r [alt_pkg::QUEUE_DEPTH];
  logic [alt_pkg::QPTR_W-1:0]      wr_r, wr_nxt;
  logic [alt_pkg::QPTR_W-1:0]      rd_r, rd_nxt;
  logic [alt_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign q_stat.full  = (cnt_r == alt_pkg::QCNT_W'(alt_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == alt_pkg::QPTR_W'(alt_pkg::QUEUE_DEPTH - 1)) ? '0 :
               wr_r + alt_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == alt_pkg::QPTR_W'(alt_pkg::QUEUE_DEPTH - 1)) ? '0 :
               rd_r + alt_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + alt_pkg::QCNT_W'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - alt_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

`default_nettype wire

[rtl/core/alt_back.sv]
// ----------------------------------------------------------------------------
// alt_back
// splits queued descriptor pairs into single items on the output register
// ----------------------------------------------------------------------------
`default_nettype none

module alt_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire alt_pkg::entry_t  head,
  input  wire alt_pkg::q_stat_t q_stat,
  output logic                  pop,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output alt_pkg::out_t         out_data,
  output alt_pkg::back_stat_t   back_stat
);

  logic          out_valid_r, out_valid_nxt;
  alt_pkg::out_t out_data_r, out_data_nxt;
  logic          hold_r, hold_nxt;
  alt_pkg::out_t hold_d_r, hold_d_nxt;
  logic          slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign pop       = slot_free && !hold_r && !q_stat.empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    hold_nxt      = hold_r;
    hold_d_nxt    = hold_d_r;
    if (slot_free) begin
      if (hold_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = hold_d_r;
        hold_nxt      = 1'b0;
      end else if (!q_stat.empty) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = head.d0;
        hold_nxt      = head.two;
        hold_d_nxt    = head.d1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hold_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hold_r      <= hold_nxt;
    end
    out_data_r <= out_data_nxt;
    hold_d_r   <= hold_d_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_data             = out_data_r;
  assign back_stat.hold_valid = hold_r;
  assign back_stat.hold_last  = hold_d_r.last;

endmodule

`default_nettype wire

[rtl/core/asm_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// asm_line_tokenizer
// assembler line tokenizer: one character in, token descriptors out
// ----------------------------------------------------------------------------
// Takes one source character per cycle and emits start column, length and
// kind of each token. The per-character state update is combinational, so
// the input takes one item every cycle while the four-entry descriptor queue
// has room. A character with two descriptors sends them out one after the
// other; the output side delivers one descriptor per cycle while out_ready
// is high, so the sustained input rate is one character per cycle when
// characters average at most one descriptor each. Descriptors pass a queue
// entry, then the output register. No clearing pass is needed after reset.
`default_nettype none
`include "asm_line_tokenizer_macros.svh"

module asm_line_tokenizer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire alt_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output alt_pkg::out_t      out_data
);

  logic                q_push;
  alt_pkg::entry_t     q_wdata;
  logic                q_pop;
  alt_pkg::entry_t     q_head;
  alt_pkg::q_stat_t    q_stat;
  alt_pkg::back_stat_t back_stat;

  alt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .in_ready  (in_ready),
    .push      (q_push),
    .push_data (q_wdata)
  );

  alt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .q_stat    (q_stat)
  );

  alt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .back_stat (back_stat)
  );

  `ALT_ASSERT_NOW(a_hold_has_out, clk, rst_n, back_stat.hold_valid, out_valid)
  `ALT_ASSERT_NOW(a_hold_is_last, clk, rst_n, back_stat.hold_valid, back_stat.hold_last)
  `ALT_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && out_ready && !out_data.last,
                   out_valid)
  `ALT_ASSERT_NEXT(a_queue_drains, clk, rst_n, !q_stat.empty && !out_valid, out_valid)

endmodule

`default_nettype wire
